// File: design/line_sensor_average_classify_unit_assert.svh
// Assertion macros shared by the line sensor unit.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef LINE_SENSOR_AVERAGE_CLASSIFY_UNIT_ASSERT_SVH
`define LINE_SENSOR_AVERAGE_CLASSIFY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define LSAC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LSAC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LSAC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LSAC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: design/lsac_pkg.sv
package lsac_pkg;

  // Field widths.
  localparam int FREQ_W  = 17;
  localparam int NORM_W  = 16;
  localparam int LEVEL_W = 15;
  localparam int SURF_W  = 2;
  localparam int LANES   = 3;

  // Moving average window.
  localparam int WINDOW_LEN = 10;
  localparam int SLOT_W     = $clog2(WINDOW_LEN);
  localparam int TOTAL_W    = FREQ_W + $clog2(WINDOW_LEN);

  // Window average by reciprocal multiplication. The shift is wide enough that
  // the rounded-up reciprocal gives the exact truncated quotient for every total.
  localparam int AVG_SHIFT  = TOTAL_W + SLOT_W;
  localparam int AVG_PROD_W = TOTAL_W + AVG_SHIFT;
  localparam logic [AVG_SHIFT-1:0] AVG_RECIP =
      AVG_SHIFT'(((longint'(1) << AVG_SHIFT) + longint'(WINDOW_LEN) - 1)
                 / longint'(WINDOW_LEN));

  // Q2.14 scaling and the serial divider that serves it.
  localparam int FRAC_W    = 14;
  localparam int DIV_W     = FREQ_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Deviation weights and product width.
  localparam int PROD_W = 31;
  localparam logic signed [13:0] DEV_K_THREE = 14'sd3840;
  localparam logic signed [13:0] DEV_K_ONE   = 14'sd4595;
  localparam logic signed [16:0] NORM_ONE_Q  = 17'sd16384;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WOOD_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WOOD_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_THREE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WOOD_THREE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WOOD_LEVEL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LVL  = 3'd7;

  // Register reset values.
  localparam logic [FREQ_W-1:0]  RST_TAPE_ONE   = 17'd21500;
  localparam logic [FREQ_W-1:0]  RST_WOOD_ONE   = 17'd45800;
  localparam logic [FREQ_W-1:0]  RST_TAPE_TWO   = 17'd21000;
  localparam logic [FREQ_W-1:0]  RST_WOOD_TWO   = 17'd60000;
  localparam logic [FREQ_W-1:0]  RST_TAPE_THREE = 17'd20000;
  localparam logic [FREQ_W-1:0]  RST_WOOD_THREE = 17'd41500;
  localparam logic [LEVEL_W-1:0] RST_WOOD_LEVEL = 15'd13107;
  localparam logic [LEVEL_W-1:0] RST_BLACK_LVL  = 15'd983;

  typedef logic [FREQ_W-1:0]        freq_t;
  typedef logic signed [NORM_W-1:0] norm_t;

  typedef enum logic [SURF_W-1:0] {
    SURF_WOOD  = 2'd0,
    SURF_BLACK = 2'd1,
    SURF_RED   = 2'd2
  } surface_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_NORM_START,
    ST_NORM_WAIT,
    ST_MUL,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_start;
    logic latch_avg;
    logic latch_norm;
    logic latch_mul;
    logic load_out;
  } lsac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_free;
  } lsac_sts_t;

endpackage

// File: design/lsac_if.sv
// Input channel: one transfer carries a reading from each of the three sensors.
interface lsac_in_if;
  logic                         valid;
  logic                         ready;
  logic [lsac_pkg::FREQ_W-1:0]  freq_one;
  logic [lsac_pkg::FREQ_W-1:0]  freq_two;
  logic [lsac_pkg::FREQ_W-1:0]  freq_three;

  modport source (output valid, output freq_one, output freq_two, output freq_three,
                  input ready);
  modport sink   (input valid, input freq_one, input freq_two, input freq_three,
                  output ready);
endinterface

// Result channel: averages, normalised values, surface class and deviation.
interface lsac_out_if;
  logic                                valid;
  logic                                ready;
  logic [lsac_pkg::FREQ_W-1:0]         avg_one;
  logic [lsac_pkg::FREQ_W-1:0]         avg_two;
  logic [lsac_pkg::FREQ_W-1:0]         avg_three;
  logic signed [lsac_pkg::NORM_W-1:0]  norm_one;
  logic signed [lsac_pkg::NORM_W-1:0]  norm_two;
  logic signed [lsac_pkg::NORM_W-1:0]  norm_three;
  logic [lsac_pkg::SURF_W-1:0]         surface;
  logic signed [lsac_pkg::NORM_W-1:0]  deviation;

  modport source (output valid, output avg_one, output avg_two, output avg_three,
                  output norm_one, output norm_two, output norm_three,
                  output surface, output deviation, input ready);
  modport sink   (input valid, input avg_one, input avg_two, input avg_three,
                  input norm_one, input norm_two, input norm_three,
                  input surface, input deviation, output ready);
endinterface

// File: design/line_sensor_average_classify_unit.sv
// The block takes one item at a time: it accepts no new input until the previous
// item has left the sequencer, whose run is set by the 31-step pass of the three
// serial divider lanes that scale each window average onto its calibration span.
// A result waiting in the output register does not block the next input.
// Reset (rst_n, synchronous, active low) clears the sample rings, totals and
// ring position, and loads the calibration registers with their defaults.
module line_sensor_average_classify_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  lsac_in_if.sink                         in_ch,
  lsac_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lsac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsac_pkg::FREQ_W-1:0]     cfg_wdata
);

  lsac_pkg::lsac_cmd_t cmd;
  lsac_pkg::lsac_sts_t sts;
  logic                in_ready;

  logic [lsac_pkg::LANES-1:0][lsac_pkg::FREQ_W-1:0] freq;
  logic [lsac_pkg::LANES-1:0][lsac_pkg::FREQ_W-1:0] out_avg;
  logic [lsac_pkg::LANES-1:0][lsac_pkg::NORM_W-1:0] out_norm;
  logic [lsac_pkg::SURF_W-1:0]                      out_surface;
  logic [lsac_pkg::NORM_W-1:0]                      out_deviation;
  logic                                             out_valid;

  // Pack the sensor readings into lanes.
  assign freq[0] = in_ch.freq_one;
  assign freq[1] = in_ch.freq_two;
  assign freq[2] = in_ch.freq_three;
  assign in_ch.ready = in_ready;

  lsac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsac_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .freq          (freq),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ch.ready),
    .out_avg       (out_avg),
    .out_norm      (out_norm),
    .out_surface   (out_surface),
    .out_deviation (out_deviation)
  );

  // Drive the result channel.
  assign out_ch.valid      = out_valid;
  assign out_ch.avg_one    = out_avg[0];
  assign out_ch.avg_two    = out_avg[1];
  assign out_ch.avg_three  = out_avg[2];
  assign out_ch.norm_one   = $signed(out_norm[0]);
  assign out_ch.norm_two   = $signed(out_norm[1]);
  assign out_ch.norm_three = $signed(out_norm[2]);
  assign out_ch.surface    = out_surface;
  assign out_ch.deviation  = $signed(out_deviation);

endmodule

// File: design/lsac_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lsac_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lsac_pkg::DIV_W-1:0]    dividend,
  input  logic [lsac_pkg::FREQ_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [lsac_pkg::DIV_W-1:0]    quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic [lsac_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [lsac_pkg::DIV_W-1:0]        q_r;
  logic [lsac_pkg::FREQ_W-1:0]       rem_r;
  logic [lsac_pkg::FREQ_W-1:0]       div_r;

  logic [lsac_pkg::FREQ_W:0]         rem_sh;
  logic                              ge;
  logic [lsac_pkg::FREQ_W:0]         rem_sub;

  // Shift in the next dividend bit and trial-subtract the divisor.
  always_comb begin
    rem_sh  = {rem_r, q_r[lsac_pkg::DIV_W-1]};
    ge      = (rem_sh >= {1'b0, div_r});
    rem_sub = rem_sh - {1'b0, div_r};
  end

  // Control: busy while the quotient bits are stepped out, done pulses after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= lsac_pkg::DIV_CNT_W'(lsac_pkg::DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits replace dividend bits from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[lsac_pkg::DIV_W-2:0], ge};
      rem_r <= ge ? rem_sub[lsac_pkg::FREQ_W-1:0] : rem_sh[lsac_pkg::FREQ_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: design/lsac_ctrl.sv
`include "line_sensor_average_classify_unit_assert.svh"

// Sequencer: accept, average, normalise divide, multiply, finish.
module lsac_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lsac_pkg::lsac_sts_t  sts,
  output lsac_pkg::lsac_cmd_t  cmd
);

  lsac_pkg::state_t state_r;
  lsac_pkg::state_t state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsac_pkg::ST_IDLE:       if (in_valid) state_nxt = lsac_pkg::ST_AVG;
      lsac_pkg::ST_AVG:        state_nxt = lsac_pkg::ST_NORM_START;
      lsac_pkg::ST_NORM_START: state_nxt = lsac_pkg::ST_NORM_WAIT;
      lsac_pkg::ST_NORM_WAIT:  if (sts.div_done) state_nxt = lsac_pkg::ST_MUL;
      lsac_pkg::ST_MUL:        state_nxt = lsac_pkg::ST_FINISH;
      lsac_pkg::ST_FINISH:     if (sts.out_free) state_nxt = lsac_pkg::ST_IDLE;
      default:                 state_nxt = lsac_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      lsac_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lsac_pkg::ST_AVG: begin
        cmd.latch_avg = 1'b1;
      end
      lsac_pkg::ST_NORM_START: begin
        cmd.div_start = 1'b1;
      end
      lsac_pkg::ST_NORM_WAIT: begin
        cmd.latch_norm = sts.div_done;
      end
      lsac_pkg::ST_MUL: begin
        cmd.latch_mul = 1'b1;
      end
      lsac_pkg::ST_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsac_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The dividers must be running in the cycle after a start.
  `LSAC_ASSERT_NXT(a_div_runs, clk, rst_n, state_r == lsac_pkg::ST_NORM_START,
                   sts.div_busy, "divider did not start")
  // A divider completion is only expected while waiting for it.
  `LSAC_ASSERT_IMP(a_done_in_wait, clk, rst_n, sts.div_done,
                   state_r == lsac_pkg::ST_NORM_WAIT, "unexpected divider completion")
  // Once the result is handed over the sequencer is ready for the next item.
  `LSAC_ASSERT_NXT(a_finish_idle, clk, rst_n,
                   state_r == lsac_pkg::ST_FINISH && sts.out_free,
                   state_r == lsac_pkg::ST_IDLE && in_ready, "finish did not return to idle")

endmodule

// File: design/lsac_dp.sv
// Datapath: sample rings, running totals, divider lanes, scaling and classification.
module lsac_dp (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [lsac_pkg::LANES-1:0][lsac_pkg::FREQ_W-1:0] freq,
  input  logic                                          cfg_we,
  input  logic [lsac_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [lsac_pkg::FREQ_W-1:0]                   cfg_wdata,
  input  lsac_pkg::lsac_cmd_t                           cmd,
  output lsac_pkg::lsac_sts_t                           sts,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [lsac_pkg::LANES-1:0][lsac_pkg::FREQ_W-1:0] out_avg,
  output logic [lsac_pkg::LANES-1:0][lsac_pkg::NORM_W-1:0] out_norm,
  output logic [lsac_pkg::SURF_W-1:0]                   out_surface,
  output logic [lsac_pkg::NORM_W-1:0]                   out_deviation
);

  localparam int L = lsac_pkg::LANES;

  // Configuration registers.
  lsac_pkg::freq_t                tape_r [L];
  lsac_pkg::freq_t                wood_r [L];
  logic [lsac_pkg::LEVEL_W-1:0]   wood_lvl_r;
  logic [lsac_pkg::LEVEL_W-1:0]   black_lvl_r;

  // Window state.
  lsac_pkg::freq_t                ring_r  [L][lsac_pkg::WINDOW_LEN];
  logic [lsac_pkg::TOTAL_W-1:0]   total_r [L];
  logic [lsac_pkg::TOTAL_W-1:0]   total_nxt [L];
  logic [lsac_pkg::SLOT_W-1:0]    slot_r;
  logic [lsac_pkg::SLOT_W-1:0]    slot_nxt;

  // Per-item working registers.
  lsac_pkg::freq_t                avg_r  [L];
  lsac_pkg::norm_t                norm_r [L];
  logic signed [lsac_pkg::PROD_W-1:0] prod_one_r;
  logic signed [lsac_pkg::PROD_W-1:0] prod_three_r;

  // Window average products.
  logic [lsac_pkg::AVG_PROD_W-1:0] avg_prod [L];

  // Divider lanes.
  logic [lsac_pkg::DIV_W-1:0]     div_dividend [L];
  logic [lsac_pkg::FREQ_W-1:0]    div_divisor  [L];
  logic [lsac_pkg::DIV_W-1:0]     div_quot     [L];
  logic [L-1:0]                   div_busy;
  logic [L-1:0]                   div_done;

  logic [lsac_pkg::FREQ_W:0]      diff    [L];
  logic [lsac_pkg::FREQ_W:0]      span    [L];
  logic [lsac_pkg::FREQ_W-1:0]    mag     [L];
  logic                           neg     [L];
  logic                           empty   [L];
  lsac_pkg::norm_t                norm_sat [L];

  logic signed [lsac_pkg::FREQ_W-1:0] d_one;
  logic signed [lsac_pkg::FREQ_W-1:0] d_three;
  logic signed [lsac_pkg::PROD_W:0]   dev_diff;

  logic [lsac_pkg::LEVEL_W+1:0]   wl_x3;
  logic signed [lsac_pkg::FREQ_W-1:0] wl_s;
  logic signed [lsac_pkg::FREQ_W-1:0] wl34_s;
  logic signed [lsac_pkg::FREQ_W-1:0] bl_s;
  logic signed [lsac_pkg::FREQ_W-1:0] n_s [L];
  logic [L-1:0]                   hi;
  logic [L-1:0]                   hi34;
  logic [L-1:0]                   lo;
  lsac_pkg::surface_t             surf;

  // Output register.
  logic                           out_valid_r;
  lsac_pkg::freq_t                out_avg_r  [L];
  lsac_pkg::norm_t                out_norm_r [L];
  lsac_pkg::surface_t             out_surf_r;
  lsac_pkg::norm_t                out_dev_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tape_r[0]   <= lsac_pkg::RST_TAPE_ONE;
      wood_r[0]   <= lsac_pkg::RST_WOOD_ONE;
      tape_r[1]   <= lsac_pkg::RST_TAPE_TWO;
      wood_r[1]   <= lsac_pkg::RST_WOOD_TWO;
      tape_r[2]   <= lsac_pkg::RST_TAPE_THREE;
      wood_r[2]   <= lsac_pkg::RST_WOOD_THREE;
      wood_lvl_r  <= lsac_pkg::RST_WOOD_LEVEL;
      black_lvl_r <= lsac_pkg::RST_BLACK_LVL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsac_pkg::CFG_TAPE_ONE:   tape_r[0]   <= cfg_wdata;
        lsac_pkg::CFG_WOOD_ONE:   wood_r[0]   <= cfg_wdata;
        lsac_pkg::CFG_TAPE_TWO:   tape_r[1]   <= cfg_wdata;
        lsac_pkg::CFG_WOOD_TWO:   wood_r[1]   <= cfg_wdata;
        lsac_pkg::CFG_TAPE_THREE: tape_r[2]   <= cfg_wdata;
        lsac_pkg::CFG_WOOD_THREE: wood_r[2]   <= cfg_wdata;
        lsac_pkg::CFG_WOOD_LEVEL: wood_lvl_r  <= cfg_wdata[lsac_pkg::LEVEL_W-1:0];
        lsac_pkg::CFG_BLACK_LVL:  black_lvl_r <= cfg_wdata[lsac_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Running totals: add the new sample and drop the one it replaces.
  always_comb begin
    for (int l = 0; l < L; l++) begin
      total_nxt[l] = total_r[l] + lsac_pkg::TOTAL_W'(freq[l])
                   - lsac_pkg::TOTAL_W'(ring_r[l][slot_r]);
    end
    if (slot_r == lsac_pkg::SLOT_W'(lsac_pkg::WINDOW_LEN - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < L; l++) begin
        total_r[l] <= '0;
        for (int i = 0; i < lsac_pkg::WINDOW_LEN; i++) begin
          ring_r[l][i] <= '0;
        end
      end
      slot_r <= '0;
    end else if (cmd.accept) begin
      for (int l = 0; l < L; l++) begin
        total_r[l]         <= total_nxt[l];
        ring_r[l][slot_r]  <= freq[l];
      end
      slot_r <= slot_nxt;
    end
  end

  // Window average: the total times the reciprocal of the window length.
  always_comb begin
    for (int l = 0; l < L; l++) begin
      avg_prod[l] = lsac_pkg::AVG_PROD_W'(total_r[l])
                  * lsac_pkg::AVG_PROD_W'(lsac_pkg::AVG_RECIP);
    end
  end

  // Divider operands: the offset from tape scaled to Q2.14 over the
  // calibration span.
  always_comb begin
    for (int l = 0; l < L; l++) begin
      diff[l]  = {1'b0, avg_r[l]} - {1'b0, tape_r[l]};
      span[l]  = {1'b0, wood_r[l]} - {1'b0, tape_r[l]};
      neg[l]   = diff[l][lsac_pkg::FREQ_W];
      mag[l]   = neg[l] ? (lsac_pkg::FREQ_W'(0) - diff[l][lsac_pkg::FREQ_W-1:0])
                        : diff[l][lsac_pkg::FREQ_W-1:0];
      empty[l] = span[l][lsac_pkg::FREQ_W] || (span[l] == '0);
      div_dividend[l] = {mag[l], lsac_pkg::FRAC_W'(0)};
      div_divisor[l]  = span[l][lsac_pkg::FREQ_W-1:0];
    end
  end

  for (genvar g = 0; g < L; g++) begin : g_div
    lsac_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (cmd.div_start),
      .dividend (div_dividend[g]),
      .divisor  (div_divisor[g]),
      .busy     (div_busy[g]),
      .done     (div_done[g]),
      .quotient (div_quot[g])
    );
  end

  // Apply the sign and saturate the quotient magnitude to 16 bits.
  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (empty[l]) begin
        norm_sat[l] = '0;
      end else if (!neg[l]) begin
        if (|div_quot[l][lsac_pkg::DIV_W-1:lsac_pkg::NORM_W-1]) begin
          norm_sat[l] = 16'sh7FFF;
        end else begin
          norm_sat[l] = $signed({1'b0, div_quot[l][lsac_pkg::NORM_W-2:0]});
        end
      end else begin
        if ((|div_quot[l][lsac_pkg::DIV_W-1:lsac_pkg::NORM_W]) ||
            (div_quot[l][lsac_pkg::NORM_W-1] && (|div_quot[l][lsac_pkg::NORM_W-2:0]))) begin
          norm_sat[l] = 16'sh8000;
        end else begin
          norm_sat[l] = $signed(lsac_pkg::NORM_W'(0) - div_quot[l][lsac_pkg::NORM_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_avg) begin
      for (int l = 0; l < L; l++) begin
        avg_r[l] <= avg_prod[l][lsac_pkg::AVG_SHIFT +: lsac_pkg::FREQ_W];
      end
    end
    if (cmd.latch_norm) begin
      for (int l = 0; l < L; l++) begin
        norm_r[l] <= norm_sat[l];
      end
    end
  end

  // Deviation products, registered before the subtraction.
  always_comb begin
    d_one   = lsac_pkg::NORM_ONE_Q - $signed({norm_r[0][lsac_pkg::NORM_W-1], norm_r[0]});
    d_three = lsac_pkg::NORM_ONE_Q - $signed({norm_r[2][lsac_pkg::NORM_W-1], norm_r[2]});
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_mul) begin
      prod_one_r   <= d_one * lsac_pkg::DEV_K_ONE;
      prod_three_r <= d_three * lsac_pkg::DEV_K_THREE;
    end
  end

  // Deviation and surface class.
  always_comb begin
    dev_diff = prod_three_r - prod_one_r;
    wl_x3    = {2'b00, wood_lvl_r} + {1'b0, wood_lvl_r, 1'b0};
    wl_s     = $signed({2'b00, wood_lvl_r});
    wl34_s   = $signed({2'b00, wl_x3[lsac_pkg::LEVEL_W+1:2]});
    bl_s     = $signed({2'b00, black_lvl_r});
    for (int l = 0; l < L; l++) begin
      n_s[l]  = $signed({norm_r[l][lsac_pkg::NORM_W-1], norm_r[l]});
      hi[l]   = n_s[l] > wl_s;
      hi34[l] = n_s[l] > wl34_s;
      lo[l]   = n_s[l] < bl_s;
    end
    if ((hi[0] && hi[1]) || (hi[0] && hi[2]) || (hi[1] && hi[2]) || (&hi34)) begin
      surf = lsac_pkg::SURF_WOOD;
    end else if ((lo[0] && lo[1]) || (lo[0] && lo[2]) || (lo[1] && lo[2])) begin
      surf = lsac_pkg::SURF_BLACK;
    end else begin
      surf = lsac_pkg::SURF_RED;
    end
  end

  // Output register: holds one result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int l = 0; l < L; l++) begin
        out_avg_r[l]  <= avg_r[l];
        out_norm_r[l] <= norm_r[l];
      end
      out_surf_r <= surf;
      out_dev_r  <= $signed(dev_diff[lsac_pkg::FRAC_W+lsac_pkg::NORM_W-1:lsac_pkg::FRAC_W]);
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      out_avg[l]  = out_avg_r[l];
      out_norm[l] = out_norm_r[l];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_surface   = out_surf_r;
  assign out_deviation = out_dev_r;

  assign sts.div_busy = &div_busy;
  assign sts.div_done = &div_done;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// File: sim/line_sensor_average_classify_unit_tb.sv
module line_sensor_average_classify_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsac_pkg::*;

  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 78;
  localparam int PRINT_LIMIT   = 60;
  localparam int FREQ_MAX      = (1 << FREQ_W) - 1;

  // One result transfer, lane 0 being sensor one.
  typedef struct packed {
    freq_t    [LANES-1:0] avg;
    norm_t    [LANES-1:0] norm;
    surface_t             surface;
    norm_t                deviation;
  } sensor_result_t;

  typedef enum {SINK_FREE, SINK_COIN, SINK_SPARSE, SINK_LONG_STALL} sink_mode_t;
  typedef enum {RUN_STEADY, RUN_NOISE, RUN_JUMP} run_kind_t;
  typedef enum {BAND_BLACK, BAND_RED, BAND_NEAR_WOOD, BAND_WOOD, BAND_WILD} band_t;

  // Mirrors the calibration, the sample rings and the queue of awaited readouts.
  class sensor_result_ledger;
    freq_t              tape_cal [LANES];
    freq_t              wood_cal [LANES];
    logic [LEVEL_W-1:0] wood_level;
    logic [LEVEL_W-1:0] black_level;
    freq_t              history [LANES][WINDOW_LEN];
    int unsigned        running_sum [LANES];
    int unsigned        slot;
    sensor_result_t     awaited_readouts [$];
    int unsigned        mismatches;
    int unsigned        readings;
    int unsigned        readouts;
    int unsigned        wood_count;
    int unsigned        black_count;
    int unsigned        red_count;

    function new();
      tape_cal = '{RST_TAPE_ONE, RST_TAPE_TWO, RST_TAPE_THREE};
      wood_cal = '{RST_WOOD_ONE, RST_WOOD_TWO, RST_WOOD_THREE};
      wood_level = RST_WOOD_LEVEL;
      black_level = RST_BLACK_LVL;
      foreach (history[l, k]) history[l][k] = '0;
      foreach (running_sum[l]) running_sum[l] = 0;
      slot = 0;
      mismatches = 0;
      readings = 0;
      readouts = 0;
      wood_count = 0;
      black_count = 0;
      red_count = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, freq_t data);
      case (idx)
        CFG_TAPE_ONE:   tape_cal[0] = data;
        CFG_WOOD_ONE:   wood_cal[0] = data;
        CFG_TAPE_TWO:   tape_cal[1] = data;
        CFG_WOOD_TWO:   wood_cal[1] = data;
        CFG_TAPE_THREE: tape_cal[2] = data;
        CFG_WOOD_THREE: wood_cal[2] = data;
        CFG_WOOD_LEVEL: wood_level = data[LEVEL_W-1:0];
        CFG_BLACK_LVL:  black_level = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // Linear map of an average onto Q2.14, truncated toward zero and saturated.
    function longint scale_to_q14(freq_t avg, freq_t tape, freq_t wood);
      longint q;
      if (wood <= tape) return 0;
      q = (longint'(avg) - longint'(tape)) * (longint'(1) << FRAC_W)
          / (longint'(wood) - longint'(tape));
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
    endfunction

    // Advances the rings with an accepted reading and queues the readout it causes.
    function void record_reading(freq_t f1, freq_t f2, freq_t f3);
      freq_t          sample [LANES];
      sensor_result_t r;
      longint         q [LANES];
      longint         wl, wl34, bl, dev;
      int             high_count, low_count, upper_count;
      sample = '{f1, f2, f3};
      high_count = 0;
      low_count = 0;
      upper_count = 0;
      for (int l = 0; l < LANES; l++) begin
        running_sum[l] = running_sum[l] + sample[l] - history[l][slot];
        history[l][slot] = sample[l];
        r.avg[l] = freq_t'(running_sum[l] / WINDOW_LEN);
        q[l] = scale_to_q14(r.avg[l], tape_cal[l], wood_cal[l]);
        r.norm[l] = norm_t'(q[l]);
      end
      slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;

      // Surface class from the three normalised values.
      wl = wood_level;
      wl34 = (wl * 3) >>> 2;
      bl = black_level;
      for (int l = 0; l < LANES; l++) begin
        if (q[l] > wl) high_count++;
        if (q[l] < bl) low_count++;
        if (q[l] > wl34) upper_count++;
      end
      if (high_count >= 2 || upper_count == LANES) begin
        r.surface = SURF_WOOD;
      end else if (low_count >= 2) begin
        r.surface = SURF_BLACK;
      end else begin
        r.surface = SURF_RED;
      end

      // Deviation rounds toward minus infinity.
      dev = longint'(DEV_K_THREE) * (longint'(NORM_ONE_Q) - q[2])
            - longint'(DEV_K_ONE) * (longint'(NORM_ONE_Q) - q[0]);
      r.deviation = norm_t'(dev >>> FRAC_W);
      awaited_readouts.push_back(r);
      readings++;
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
        if (mismatches == PRINT_LIMIT) begin
          $display("%0t: further mismatches are counted but not shown", $time);
        end
      end
    endfunction

    // Compares a result transfer with the oldest awaited readout.
    function void check_result(sensor_result_t got);
      sensor_result_t want;
      readouts++;
      if (awaited_readouts.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing awaited, expected none, actual avg %0d/%0d/%0d",
                 $time, got.avg[0], got.avg[1], got.avg[2]);
        return;
      end
      want = awaited_readouts.pop_front();
      for (int l = 0; l < LANES; l++) begin
        compare_field($sformatf("avg_%0d", l + 1), want.avg[l], got.avg[l]);
        compare_field($sformatf("norm_%0d", l + 1), $signed(want.norm[l]),
                      $signed(got.norm[l]));
      end
      compare_field("surface", want.surface, got.surface);
      compare_field("deviation", $signed(want.deviation), $signed(got.deviation));
      case (want.surface)
        SURF_WOOD:  wood_count++;
        SURF_BLACK: black_count++;
        default:    red_count++;
      endcase
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  freq_t                cfg_wdata;

  lsac_in_if  in_ch ();
  lsac_out_if out_ch ();

  sensor_result_ledger ledger;
  int                  burst_left;
  int                  gap_max;

  line_sensor_average_classify_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic freq_t jitter(freq_t level);
    int v;
    v = int'(level) + pick(-40, 40);
    if (v < 0) v = 0;
    if (v > FREQ_MAX) v = FREQ_MAX;
    return freq_t'(v);
  endfunction

  // A frequency whose normalised value falls in the given band under the
  // current calibration of that sensor.
  function automatic freq_t level_for(int lane, band_t band);
    longint wl, wl34, bl, span, norm, level;
    wl = ledger.wood_level;
    wl34 = (wl * 3) >>> 2;
    bl = ledger.black_level;
    span = longint'(ledger.wood_cal[lane]) - longint'(ledger.tape_cal[lane]);
    if (span <= 0) return freq_t'($urandom);
    case (band)
      BAND_BLACK:     norm = bl - pick(1, 3000);
      BAND_RED:       norm = bl + (wl34 - bl) * pick(1, 999) / 1000;
      BAND_NEAR_WOOD: norm = wl34 + (wl - wl34) * pick(1, 999) / 1000;
      BAND_WOOD:      norm = wl + pick(1, 6000);
      default:        norm = pick(-40000, 40000);
    endcase
    level = longint'(ledger.tape_cal[lane]) + norm * span / (longint'(1) << FRAC_W);
    if (level < 0) level = 0;
    if (level > FREQ_MAX) level = FREQ_MAX;
    return freq_t'(level);
  endfunction

  // Offers one reading and returns at the falling edge after its transfer.
  // Valid stays high between readings of a burst.
  task automatic send_reading(freq_t f1, freq_t f2, freq_t f3);
    int gap;
    if (burst_left == 0) begin
      burst_left = pick(1, 12);
      gap = (gap_max == 0) ? 0 : pick(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.freq_one <= f1;
    in_ch.freq_two <= f2;
    in_ch.freq_three <= f3;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Mostly steady runs long enough to fill the window, plus noise and short jumps.
  task automatic play_sequences(int count);
    run_kind_t kind;
    band_t     common_band;
    bit        shared;
    freq_t     level [LANES];
    int        length;
    int        sent;
    sent = 0;
    while (sent < count) begin
      if (pick(0, 9) < 7) begin
        kind = RUN_STEADY;
      end else if (pick(0, 1) == 0) begin
        kind = RUN_NOISE;
      end else begin
        kind = RUN_JUMP;
      end
      shared = (pick(0, 2) == 0);
      common_band = band_t'(pick(0, 4));
      for (int l = 0; l < LANES; l++) begin
        level[l] = level_for(l, shared ? common_band : band_t'(pick(0, 4)));
      end
      case (kind)
        RUN_STEADY: length = pick(WINDOW_LEN, 2 * WINDOW_LEN);
        RUN_JUMP:   length = pick(1, 4);
        default:    length = pick(1, 8);
      endcase
      repeat (length) begin
        if (kind == RUN_NOISE) begin
          send_reading(freq_t'($urandom), freq_t'($urandom), freq_t'($urandom));
        end else begin
          send_reading(jitter(level[0]), jitter(level[1]), jitter(level[2]));
        end
        sent++;
      end
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, freq_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    ledger.set_register(idx, data);
    @(negedge clk);
  endtask

  // Holds the sender off until every awaited readout has arrived.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (ledger.awaited_readouts.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Full spans, empty spans, one-step spans, then random calibrations.
  task automatic apply_setting(int phase);
    freq_t tape [LANES];
    freq_t wood [LANES];
    freq_t wl_data;
    freq_t bl_data;
    int    w;
    case (phase)
      1: begin
        tape = '{'0, '0, '0};
        wood = '{'1, '1, '1};
        wl_data = '1;
        bl_data = '0;
      end
      2: begin
        tape = '{17'd50000, '1, 17'd1001};
        wood = '{17'd50000, '0, 17'd1000};
        wl_data = '0;
        bl_data = 17'h07FFF;
      end
      3: begin
        tape = '{17'd65536, 17'd131070, '0};
        wood = '{17'd65537, '1, 17'd1};
        wl_data = 17'd16384;
        bl_data = 17'h10000 | 17'd200;
      end
      default: begin
        for (int l = 0; l < LANES; l++) begin
          tape[l] = freq_t'(pick(2000, 60000));
          w = int'(tape[l]) + pick(500, 70000);
          wood[l] = freq_t'((w > FREQ_MAX) ? FREQ_MAX : w);
        end
        wl_data = freq_t'(pick(6000, 20000) + (pick(0, 3) << LEVEL_W));
        bl_data = freq_t'(pick(100, 4000) + (pick(0, 3) << LEVEL_W));
      end
    endcase
    write_register(CFG_TAPE_ONE, tape[0]);
    write_register(CFG_WOOD_ONE, wood[0]);
    write_register(CFG_TAPE_TWO, tape[1]);
    write_register(CFG_WOOD_TWO, wood[1]);
    write_register(CFG_TAPE_THREE, tape[2]);
    write_register(CFG_WOOD_THREE, wood[2]);
    write_register(CFG_WOOD_LEVEL, wl_data);
    write_register(CFG_BLACK_LVL, bl_data);
  endtask

  // Both channels are sampled at the rising edge; results are checked first.
  always @(posedge clk) begin : transfer_monitor
    sensor_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.avg[0] = out_ch.avg_one;
        got.avg[1] = out_ch.avg_two;
        got.avg[2] = out_ch.avg_three;
        got.norm[0] = out_ch.norm_one;
        got.norm[1] = out_ch.norm_two;
        got.norm[2] = out_ch.norm_three;
        got.surface = surface_t'(out_ch.surface);
        got.deviation = out_ch.deviation;
        ledger.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        ledger.record_reading(in_ch.freq_one, in_ch.freq_two, in_ch.freq_three);
      end
    end
  end

  // Receiver stalls follow a randomly picked mode that changes from stretch to stretch.
  initial begin : result_sink
    sink_mode_t mode;
    int         stretch;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      mode = sink_mode_t'(pick(0, 3));
      stretch = pick(100, 600);
      while (stretch > 0) begin
        case (mode)
          SINK_FREE:   out_ch.ready <= 1'b1;
          SINK_COIN:   out_ch.ready <= (pick(0, 1) == 1);
          SINK_SPARSE: out_ch.ready <= (pick(0, 9) == 0);
          default:     out_ch.ready <= (stretch % 97 > 60);
        endcase
        stretch--;
        @(negedge clk);
      end
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TAPE_ONE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.freq_one = '0;
    in_ch.freq_two = '0;
    in_ch.freq_three = '0;
    ledger = new();
    burst_left = 0;
    gap_max = 6;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part on the reset calibration: ramp up to full scale and back
    // to zero, with a mixed pattern that lands between the classes.
    repeat (2) send_reading('0, '0, '0);
    repeat (10) send_reading('1, '1, '1);
    repeat (6) send_reading('1, 17'd40000, '0);
    repeat (2) send_reading('0, '1, '1);
    repeat (5) send_reading('0, '0, '0);
    play_sequences(PHASE_ITEMS);

    // Random phases, each under a new calibration and sender pace.
    for (int p = 1; p < PHASES; p++) begin
      wait_for_drain();
      apply_setting(p);
      case (p % 4)
        0:       gap_max = 0;
        1:       gap_max = 8;
        2:       gap_max = 90;
        default: gap_max = 30;
      endcase
      play_sequences(PHASE_ITEMS);
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run: %0d readings, %0d results over %0d calibration settings.",
             ledger.readings, ledger.readouts, PHASES);
    $display("Surfaces seen: %0d wood, %0d black, %0d red; %0d mismatches.",
             ledger.wood_count, ledger.black_count, ledger.red_count, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.awaited_readouts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
